[rtl/core/oitt_pkg.sv]
// shared constants, codes and item types for the outstanding io timeout tracker
package oitt_pkg;

	localparam int MAX_OUTSTANDING = 64;
	localparam int IDX_W = $clog2(MAX_OUTSTANDING);
	localparam int CNT_W = $clog2(MAX_OUTSTANDING + 1);
	localparam int TIME_W = 32;
	localparam int SEQ_W = 32;
	localparam int ADDR_W = 4;

	// commands
	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_COMPLETE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	// result status codes
	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_PASS = 3'd1;
	localparam logic [2:0] STS_TIMEOUT = 3'd2;
	localparam logic [2:0] STS_FULL = 3'd3;
	localparam logic [2:0] STS_UNKNOWN = 3'd4;

	// register indexes (word address)
	localparam logic [1:0] REG_WATCHDOG = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] io_id;
	} oitt_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] assigned_id;
		logic [6:0]  timeout_count;
		logic [31:0] oldest_age;
		logic [6:0]  outstanding_count;
		logic [31:0] pass_count;
	} oitt_rsp_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] start;
	} oitt_slot_t;

	function automatic logic [6:0] sat_cnt(input logic [CNT_W-1:0] v);
		return (v > CNT_W'(127)) ? 7'h7f : 7'(v);
	endfunction

	function automatic logic [31:0] sat_age(input logic [TIME_W-1:0] a);
		return (64'(a) > 64'h0000_0000_ffff_ffff) ? {32{1'b1}} : 32'(a);
	endfunction

endpackage

[rtl/core/outstanding_io_timeout_tracker_top.sv]
// outstanding io timeout tracker: sequencer, slot valid bits, counters and apb registers
//
// Usage: drive req and raise start while busy is low; the item is taken at that edge.
// Commands: add takes the lowest free slot and returns a new sequence id, complete
// frees the slot holding io_id, tick advances time and, with the watchdog on, runs a
// check every check_period ticks over all slots. One result per item appears on rsp
// for exactly one cycle with done high; the receiver cannot stall it.
// Sequencing: no-op and ticks without a check finish at once (done the next cycle,
// busy stays low). Add walks the valid bits one slot a cycle from slot 0 up to the
// first free slot, or over all MAX_OUTSTANDING slots when none is free. Complete
// and check read the slot memory one entry a cycle through its single read port;
// complete stops at the slot that holds io_id, while a miss or a check reads every slot.
// A new item may be started in the cycle done is high; the block does not take a
// new item before it is through with the last one.
// Registers sit on the apb port at 0x0 watchdog enable, 0x4 timeout limit and
// 0x8 check period; write them only while busy is low and no result is pending.
// Reset clears all slots, time, sequence and pass counters and loads the register
// defaults; no clearing pass is needed.
module outstanding_io_timeout_tracker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [oitt_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	input  oitt_pkg::oitt_req_t           req,
	output logic                          busy,
	output logic                          done,
	output oitt_pkg::oitt_rsp_t           rsp
);
	import oitt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_FIND   = 4'b0010,
		S_LOOKUP = 4'b0100,
		S_CHECK  = 4'b1000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_OUTSTANDING - 1);

	state_t                   state_q;
	logic                     wd_on_q;
	logic [30:0]              limit_q;
	logic [30:0]              period_q;
	logic [TIME_W-1:0]        time_q;
	logic [31:0]              tsc_q;
	logic [SEQ_W-1:0]         seq_q;
	logic [31:0]              pass_q;
	logic [MAX_OUTSTANDING-1:0] valid_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         scan_idx_q;
	logic                     issue_q;
	logic                     s1_valid_q;
	logic                     done_q;

	logic [IDX_W-1:0]         idx_s1;
	logic                     vld_s1;
	logic [31:0]              id_q;
	logic [CNT_W-1:0]         tcnt_q;
	logic [TIME_W-1:0]        max_q;
	logic [2:0]               res_status_q;
	logic [31:0]              res_assigned_q;
	logic [6:0]               res_tcount_q;
	logic [31:0]              res_oldest_q;

	logic                     accept;
	logic                     cfg_wr;
	logic [31:0]              tsc_inc;
	logic                     check_due;
	logic                     slot_free;
	logic [SEQ_W-1:0]         seq_nx;
	logic                     wr_en;
	oitt_slot_t               wr_data;
	oitt_slot_t               rd_data;
	logic                     s1_last;
	logic                     id_hit;
	logic [TIME_W-1:0]        age;
	logic                     age_ge;
	logic [CNT_W-1:0]         tcnt_nx;
	logic [TIME_W-1:0]        max_nx;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_WATCHDOG: prdata = {31'd0, wd_on_q};
			REG_LIMIT:    prdata = {1'b0, limit_q};
			REG_PERIOD:   prdata = {1'b0, period_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign tsc_inc = tsc_q + 32'd1;
	// a zero period compares as due on every tick
	assign check_due = tsc_inc >= {1'b0, period_q};

	assign slot_free = !valid_q[scan_idx_q];
	assign seq_nx = seq_q + SEQ_W'(1);
	assign wr_en = (state_q == S_FIND) && slot_free;
	assign wr_data = '{seq: seq_nx, start: time_q};

	oitt_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (scan_idx_q),
		.wr_data (wr_data),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	// shared compare and age unit on the slot read back from memory
	assign s1_last = (idx_s1 == LAST_IDX);
	assign id_hit = vld_s1 && (rd_data.seq == SEQ_W'(id_q));
	assign age = time_q - rd_data.start;
	assign age_ge = 64'(age) >= 64'(limit_q);
	assign tcnt_nx = (vld_s1 && age_ge) ? tcnt_q + CNT_W'(1) : tcnt_q;
	assign max_nx = (vld_s1 && (age > max_q)) ? age : max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wd_on_q <= 1'b0;
			limit_q <= 31'd1000000;
			period_q <= 31'd1000000;
			time_q <= '0;
			tsc_q <= '0;
			seq_q <= '0;
			pass_q <= '0;
			valid_q <= '0;
			cnt_q <= '0;
			scan_idx_q <= '0;
			issue_q <= 1'b0;
			s1_valid_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_WATCHDOG: wd_on_q <= pwdata[0];
					REG_LIMIT:    limit_q <= pwdata[30:0];
					REG_PERIOD:   period_q <= pwdata[30:0];
					default:      ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					s1_valid_q <= 1'b0;
					if (accept) begin
						scan_idx_q <= '0;
						issue_q <= 1'b0;
						unique case (req.command)
							CMD_ADD: state_q <= S_FIND;
							CMD_COMPLETE: begin
								state_q <= S_LOOKUP;
								issue_q <= 1'b1;
							end
							CMD_TICK: begin
								time_q <= time_q + TIME_W'(1);
								if (!wd_on_q) begin
									tsc_q <= '0;
									done_q <= 1'b1;
								end else if (check_due) begin
									tsc_q <= '0;
									state_q <= S_CHECK;
									issue_q <= 1'b1;
								end else begin
									tsc_q <= tsc_inc;
									done_q <= 1'b1;
								end
							end
							CMD_NOP: done_q <= 1'b1;
						endcase
					end
				end
				S_FIND: begin
					if (slot_free) begin
						valid_q[scan_idx_q] <= 1'b1;
						cnt_q <= cnt_q + CNT_W'(1);
						seq_q <= seq_nx;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (scan_idx_q == LAST_IDX) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_LOOKUP, S_CHECK: begin
					// issue one memory read a cycle, evaluate it the cycle after
					s1_valid_q <= issue_q;
					if (issue_q) begin
						if (scan_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							scan_idx_q <= scan_idx_q + IDX_W'(1);
						end
					end
					if (s1_valid_q) begin
						if (state_q == S_LOOKUP) begin
							if (id_hit) begin
								valid_q[idx_s1] <= 1'b0;
								cnt_q <= cnt_q - CNT_W'(1);
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end else if (s1_last) begin
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end
						end else if (s1_last) begin
							if (tcnt_nx == '0) begin
								pass_q <= pass_q + 32'd1;
							end
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		vld_s1 <= valid_q[scan_idx_q];
		if (accept) begin
			id_q <= req.io_id;
			tcnt_q <= '0;
			max_q <= '0;
			res_status_q <= STS_OK;
			res_assigned_q <= '0;
			res_tcount_q <= '0;
			res_oldest_q <= '0;
		end
		if (state_q == S_FIND) begin
			if (slot_free) begin
				res_assigned_q <= 32'(seq_nx);
			end else if (scan_idx_q == LAST_IDX) begin
				res_status_q <= STS_FULL;
			end
		end
		if (state_q == S_LOOKUP && s1_valid_q && !id_hit && s1_last) begin
			res_status_q <= STS_UNKNOWN;
		end
		if (state_q == S_CHECK && s1_valid_q) begin
			tcnt_q <= tcnt_nx;
			max_q <= max_nx;
			if (s1_last) begin
				res_status_q <= (tcnt_nx != '0) ? STS_TIMEOUT : STS_PASS;
				res_tcount_q <= sat_cnt(tcnt_nx);
				res_oldest_q <= sat_age(max_nx);
			end
		end
	end

	assign done = done_q;
	assign rsp = '{
		status:            res_status_q,
		assigned_id:       res_assigned_q,
		timeout_count:     res_tcount_q,
		oldest_age:        res_oldest_q,
		outstanding_count: sat_cnt(cnt_q),
		pass_count:        pass_q
	};

	// outstanding count tracks the valid bits
	a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q))
		else $error("outstanding count out of step with slot valid bits");

	// every accepted item either finishes at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted item neither finished nor in progress");

	// a result is only shown once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// pass counter moves only with a passing check result
	a_pass_only_on_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(pass_q != $past(pass_q)) |-> (done && rsp.status == STS_PASS))
		else $error("pass count changed without a passing check");

endmodule

[rtl/core/oitt_table.sv]
// slot table memory: sequence id and start time per slot, registered read
module oitt_table (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [oitt_pkg::IDX_W-1:0]    wr_addr,
	input  oitt_pkg::oitt_slot_t          wr_data,
	input  logic [oitt_pkg::IDX_W-1:0]    rd_addr,
	output oitt_pkg::oitt_slot_t          rd_data
);
	import oitt_pkg::*;

	oitt_slot_t mem [MAX_OUTSTANDING];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
